// ----- hw/rtl/rcpc_pkg.sv -----
// Shared types and constants for the RC pulse capture and mode multiplexer.
`timescale 1ns / 1ps
`default_nettype none
package rcpc_pkg;

	// Width of the free-running edge timers; captured widths keep the low 16 bits.
	localparam int PULSE_BITS = 16;
	localparam int US_BITS    = 16;

	// Configuration register indexes (byte address = 4 * index).
	localparam logic [2:0] REG_MANUAL_LIMIT = 3'd0;
	localparam logic [2:0] REG_AUTO_LIMIT   = 3'd1;
	localparam logic [2:0] REG_NEUTRAL      = 3'd2;
	localparam logic [2:0] REG_DRIVE_MIN    = 3'd3;
	localparam logic [2:0] REG_DRIVE_MAX    = 3'd4;

	localparam logic [US_BITS-1:0] MANUAL_LIMIT_RST = 16'd1300;
	localparam logic [US_BITS-1:0] AUTO_LIMIT_RST   = 16'd1700;
	localparam logic [US_BITS-1:0] NEUTRAL_RST      = 16'd1500;
	localparam logic [US_BITS-1:0] DRIVE_MIN_RST    = 16'd1000;
	localparam logic [US_BITS-1:0] DRIVE_MAX_RST    = 16'd2000;
	localparam logic [US_BITS-1:0] AUX_WIDTH_RST    = 16'd2000;

	// Command value ceiling and the reciprocal used to divide by it.
	localparam logic [6:0]  CMD_MAX     = 7'd100;
	localparam logic [23:0] RECIP_100   = 24'd10737419;
	localparam int          RECIP_SHIFT = 30;

	// ASCII codes seen by the command parser.
	localparam logic [7:0] CH_OPEN  = 8'h5B;
	localparam logic [7:0] CH_CLOSE = 8'h5D;
	localparam logic [7:0] CH_M     = 8'h4D;
	localparam logic [7:0] CH_R     = 8'h52;
	localparam logic [7:0] CH_L     = 8'h4C;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	typedef enum logic [1:0] {
		MODE_MANUAL   = 2'd0,
		MODE_DISABLED = 2'd1,
		MODE_AUTO     = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		TGT_NONE  = 2'd0,
		TGT_RIGHT = 2'd1,
		TGT_LEFT  = 2'd2
	} target_t;

	typedef struct packed {
		logic [US_BITS-1:0] right;
		logic [US_BITS-1:0] left;
		logic [US_BITS-1:0] aux;
	} widths_t;

	typedef struct packed {
		logic       pending;
		target_t    target;
		logic       negative;
		logic [6:0] magnitude;
	} cmd_status_t;

	// What one tick hands to the drive stages.
	typedef struct packed {
		mode_t              mode;
		logic               applied;
		target_t            target;
		logic [6:0]         num;
		logic [US_BITS-1:0] right_w;
		logic [US_BITS-1:0] left_w;
	} tick_t;

endpackage
`default_nettype wire

// ----- hw/rtl/rcpc_capture.sv -----
// Edge timers and pulse width capture for the three receiver channels.
`timescale 1ns / 1ps
`default_nettype none
module rcpc_capture
	import rcpc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       load,
	input  wire logic [2:0] levels,
	output widths_t         widths_d
);

	logic [2:0]            prev_q;
	logic [PULSE_BITS-1:0] timer_q [3];
	logic [PULSE_BITS-1:0] timer_d [3];
	logic [US_BITS-1:0]    width_q [3];
	logic [US_BITS-1:0]    width_d [3];

	always_comb begin
		logic [PULSE_BITS+US_BITS-1:0] ext;
		for (int ch = 0; ch < 3; ch++) begin
			// restart on a rising edge, otherwise count and wrap
			if (levels[ch] && !prev_q[ch]) begin
				timer_d[ch] = '0;
			end else begin
				timer_d[ch] = timer_q[ch] + 1'b1;
			end
			ext = {{US_BITS{1'b0}}, timer_d[ch]};
			if (!levels[ch] && prev_q[ch]) begin
				width_d[ch] = ext[US_BITS-1:0];
			end else begin
				width_d[ch] = width_q[ch];
			end
		end
	end

	assign widths_d.right = width_d[0];
	assign widths_d.left  = width_d[1];
	assign widths_d.aux   = width_d[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q     <= '0;
			timer_q[0] <= '0;
			timer_q[1] <= '0;
			timer_q[2] <= '0;
			width_q[0] <= NEUTRAL_RST;
			width_q[1] <= NEUTRAL_RST;
			width_q[2] <= AUX_WIDTH_RST;
		end else if (load) begin
			prev_q <= levels;
			for (int ch = 0; ch < 3; ch++) begin
				timer_q[ch] <= timer_d[ch];
				width_q[ch] <= width_d[ch];
			end
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/rcpc_parser.sv -----
// Serial command parser for bracketed motor commands.
`timescale 1ns / 1ps
`default_nettype none
module rcpc_parser
	import rcpc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       load,
	input  wire logic       byte_valid,
	input  wire logic [7:0] rx_byte,
	input  wire logic       consume,
	output cmd_status_t     status_d
);

	typedef enum logic [1:0] {
		PH_BEFORE = 2'd0,
		PH_SIGN   = 2'd1,
		PH_DIGITS = 2'd2,
		PH_DONE   = 2'd3
	} phase_t;

	logic [1:0] seen_q, seen_d;
	logic [7:0] first_q, first_d;
	target_t    target_q, target_d;
	phase_t     phase_q, phase_d;
	logic       neg_q, neg_d;
	logic [6:0] mag_q, mag_d;
	logic       pending_q, pending_d;

	logic       is_digit;
	logic       is_space;
	logic [9:0] acc;

	assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
	assign is_space = (rx_byte == CH_SPACE) || ((rx_byte >= CH_TAB) && (rx_byte <= CH_CR));
	assign acc = ({3'b0, mag_q} << 3) + ({3'b0, mag_q} << 1) + {6'b0, rx_byte[3:0]};

	always_comb begin
		logic take_num;
		take_num  = 1'b0;
		seen_d    = seen_q;
		first_d   = first_q;
		target_d  = target_q;
		phase_d   = phase_q;
		neg_d     = neg_q;
		mag_d     = mag_q;
		pending_d = pending_q;
		if (byte_valid) begin
			if (rx_byte == CH_OPEN) begin
				seen_d    = 2'd0;
				first_d   = '0;
				target_d  = TGT_NONE;
				phase_d   = PH_BEFORE;
				neg_d     = 1'b0;
				mag_d     = '0;
				pending_d = 1'b0;
			end else if (rx_byte == CH_CLOSE) begin
				pending_d = 1'b1;
			end else if (seen_q == 2'd0) begin
				first_d = rx_byte;
				seen_d  = 2'd1;
			end else if (seen_q == 2'd1) begin
				seen_d = 2'd2;
				if (first_q == CH_M && rx_byte == CH_R) begin
					target_d = TGT_RIGHT;
				end else if (first_q == CH_M && rx_byte == CH_L) begin
					target_d = TGT_LEFT;
				end else begin
					target_d = TGT_NONE;
				end
			end else begin
				unique case (phase_q)
					PH_BEFORE: begin
						if (is_space) begin
							phase_d = PH_BEFORE;
						end else if (rx_byte == CH_PLUS || rx_byte == CH_MINUS) begin
							neg_d   = (rx_byte == CH_MINUS);
							phase_d = PH_SIGN;
						end else begin
							take_num = 1'b1;
						end
					end
					PH_SIGN, PH_DIGITS: take_num = 1'b1;
					PH_DONE:            take_num = 1'b0;
					default:            take_num = 1'b0;
				endcase
				if (take_num) begin
					if (is_digit) begin
						// saturate the accumulator at the command ceiling
						mag_d   = (acc > {3'b0, CMD_MAX}) ? CMD_MAX : acc[6:0];
						phase_d = PH_DIGITS;
					end else begin
						phase_d = PH_DONE;
					end
				end
			end
		end
	end

	assign status_d.pending   = pending_d;
	assign status_d.target    = target_d;
	assign status_d.negative  = neg_d;
	assign status_d.magnitude = mag_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q    <= '0;
			first_q   <= '0;
			target_q  <= TGT_NONE;
			phase_q   <= PH_BEFORE;
			neg_q     <= 1'b0;
			mag_q     <= '0;
			pending_q <= 1'b0;
		end else if (load) begin
			if (consume) begin
				seen_q    <= '0;
				first_q   <= '0;
				target_q  <= TGT_NONE;
				phase_q   <= PH_BEFORE;
				neg_q     <= 1'b0;
				mag_q     <= '0;
				pending_q <= 1'b0;
			end else begin
				seen_q    <= seen_d;
				first_q   <= first_d;
				target_q  <= target_d;
				phase_q   <= phase_d;
				neg_q     <= neg_d;
				mag_q     <= mag_d;
				pending_q <= pending_d;
			end
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/rcpc_drive.sv -----
// Command scaling and held output registers.
`timescale 1ns / 1ps
`default_nettype none
module rcpc_drive
	import rcpc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               load_s2,
	input  wire logic               load_out,
	input  wire tick_t              tick_s1,
	input  wire logic [US_BITS-1:0] neutral_us,
	input  wire logic [US_BITS-1:0] drive_min_us,
	input  wire logic [US_BITS-1:0] drive_max_us,
	output logic [US_BITS-1:0]      right_drive_us,
	output logic [US_BITS-1:0]      left_drive_us,
	output logic [1:0]              mode,
	output logic                    command_applied
);

	tick_t              tick_s2;
	logic signed [23:0] prod_s2;

	logic signed [16:0] span;
	logic signed [24:0] prod_full;
	logic               prod_neg;
	logic [22:0]        prod_mag;
	logic [46:0]        quot_full;
	logic [US_BITS-1:0] quot;
	logic [US_BITS-1:0] scaled;
	logic [US_BITS-1:0] right_d, left_d;

	assign span      = $signed({1'b0, drive_max_us}) - $signed({1'b0, drive_min_us});
	assign prod_full = $signed({1'b0, tick_s1.num}) * span;

	always_ff @(posedge clk) begin
		if (load_s2) begin
			tick_s2 <= tick_s1;
			prod_s2 <= prod_full[23:0];
		end
	end

	// divide by 100 on the magnitude, truncating toward zero
	assign prod_neg  = prod_s2[23];
	assign prod_mag  = prod_neg ? 23'(-prod_s2) : prod_s2[22:0];
	assign quot_full = prod_mag * RECIP_100;
	assign quot      = quot_full[RECIP_SHIFT +: US_BITS];
	assign scaled    = prod_neg ? (drive_min_us - quot) : (drive_min_us + quot);

	always_comb begin
		right_d = right_drive_us;
		left_d  = left_drive_us;
		case (tick_s2.mode)
			MODE_MANUAL: begin
				right_d = tick_s2.right_w;
				left_d  = tick_s2.left_w;
			end
			MODE_DISABLED: begin
				right_d = neutral_us;
				left_d  = neutral_us;
			end
			default: begin
				// autonomous: hold unless a command names a motor
				if (tick_s2.applied && tick_s2.target == TGT_RIGHT) begin
					right_d = scaled;
				end else if (tick_s2.applied && tick_s2.target == TGT_LEFT) begin
					left_d = scaled;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			right_drive_us  <= NEUTRAL_RST;
			left_drive_us   <= NEUTRAL_RST;
			mode            <= MODE_MANUAL;
			command_applied <= 1'b0;
		end else if (load_out) begin
			right_drive_us  <= right_d;
			left_drive_us   <= left_d;
			mode            <= tick_s2.mode;
			command_applied <= tick_s2.applied;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/rc_pulse_capture_mode_mux.sv -----
// Top level: RC pulse capture, mode selection and serial command multiplexer.
`timescale 1ns / 1ps
`default_nettype none
// One item is one microsecond tick: three receiver pin levels plus an optional
// serial byte. The block takes one item per clock while in_ready is high and
// returns one result per item (edge capture, parsing and the mode decision
// before the accepting edge, the command product in the second stage, the
// divide by 100 and the held outputs in the output stage). The per-tick
// timer and parser update is done in the acceptance cycle, so a new item can
// follow every clock; in_ready drops only when all three stages hold items and
// out_ready is low. Registers sit on an APB-style port at byte addresses
// 4*index and should be written only while no item is in flight. Nothing needs
// a clearing pass after reset.
module rc_pulse_capture_mode_mux
	import rcpc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [4:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               right_level,
	input  wire logic               left_level,
	input  wire logic               aux_level,
	input  wire logic               byte_valid,
	input  wire logic [7:0]         rx_byte,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [US_BITS-1:0]      right_drive_us,
	output logic [US_BITS-1:0]      left_drive_us,
	output logic [1:0]              mode,
	output logic                    command_applied
);

	logic [US_BITS-1:0] manual_limit_q, auto_limit_q, neutral_q, drive_min_q, drive_max_q;

	logic        cfg_write;
	logic [2:0]  reg_index;

	logic        valid_s1, valid_s2;
	logic        rdy1, rdy2, rdy3;
	logic        accept, load_s2, load_out;

	widths_t     widths_d;
	cmd_status_t status_d;
	mode_t       mode_d;
	logic        consume;
	tick_t       tick_d, tick_s1;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign reg_index = paddr[4:2];

	always_comb begin
		unique case (reg_index)
			REG_MANUAL_LIMIT: prdata = {16'b0, manual_limit_q};
			REG_AUTO_LIMIT:   prdata = {16'b0, auto_limit_q};
			REG_NEUTRAL:      prdata = {16'b0, neutral_q};
			REG_DRIVE_MIN:    prdata = {16'b0, drive_min_q};
			REG_DRIVE_MAX:    prdata = {16'b0, drive_max_q};
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			manual_limit_q <= MANUAL_LIMIT_RST;
			auto_limit_q   <= AUTO_LIMIT_RST;
			neutral_q      <= NEUTRAL_RST;
			drive_min_q    <= DRIVE_MIN_RST;
			drive_max_q    <= DRIVE_MAX_RST;
		end else if (cfg_write) begin
			unique case (reg_index)
				REG_MANUAL_LIMIT: manual_limit_q <= pwdata[US_BITS-1:0];
				REG_AUTO_LIMIT:   auto_limit_q   <= pwdata[US_BITS-1:0];
				REG_NEUTRAL:      neutral_q      <= pwdata[US_BITS-1:0];
				REG_DRIVE_MIN:    drive_min_q    <= pwdata[US_BITS-1:0];
				REG_DRIVE_MAX:    drive_max_q    <= pwdata[US_BITS-1:0];
				default:          ;
			endcase
		end
	end

	// stage handshake: a stage moves when the one after it is empty or moving
	assign rdy3     = !out_valid || out_ready;
	assign rdy2     = !valid_s2 || rdy3;
	assign rdy1     = !valid_s1 || rdy2;
	assign in_ready = rdy1;
	assign accept   = in_valid && in_ready;
	assign load_s2  = valid_s1 && rdy2;
	assign load_out = valid_s2 && rdy3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (rdy1) begin
				valid_s1 <= in_valid;
			end
			if (rdy2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy3) begin
				out_valid <= valid_s2;
			end
		end
	end

	rcpc_capture u_capture (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept),
		.levels   ({aux_level, left_level, right_level}),
		.widths_d (widths_d)
	);

	rcpc_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (accept),
		.byte_valid (byte_valid),
		.rx_byte    (rx_byte),
		.consume    (consume),
		.status_d   (status_d)
	);

	// mode from the freshly captured aux width; manual wins if limits overlap
	always_comb begin
		if (widths_d.aux <= manual_limit_q) begin
			mode_d = MODE_MANUAL;
		end else if (widths_d.aux < auto_limit_q) begin
			mode_d = MODE_DISABLED;
		end else begin
			mode_d = MODE_AUTO;
		end
	end

	assign consume = (mode_d == MODE_AUTO) && status_d.pending;

	assign tick_d.mode    = mode_d;
	assign tick_d.applied = consume;
	assign tick_d.target  = status_d.target;
	assign tick_d.num     = status_d.negative ? 7'd0 : status_d.magnitude;
	assign tick_d.right_w = widths_d.right;
	assign tick_d.left_w  = widths_d.left;

	always_ff @(posedge clk) begin
		if (accept) begin
			tick_s1 <= tick_d;
		end
	end

	rcpc_drive u_drive (
		.clk             (clk),
		.arst_n          (arst_n),
		.load_s2         (load_s2),
		.load_out        (load_out),
		.tick_s1         (tick_s1),
		.neutral_us      (neutral_q),
		.drive_min_us    (drive_min_q),
		.drive_max_us    (drive_max_q),
		.right_drive_us  (right_drive_us),
		.left_drive_us   (left_drive_us),
		.mode            (mode),
		.command_applied (command_applied)
	);

endmodule
`default_nettype wire

// ----- test/tb.sv -----
// Self-checking testbench for rc_pulse_capture_mode_mux: random pin ticks and serial commands.
`timescale 1ns / 1ps
module tb
	import rcpc_pkg::*;
();

	localparam int CYCLE_LIMIT = 500000;
	localparam int LONG_HOLD   = 300;

	typedef enum logic [1:0] {
		NUM_LEAD   = 2'd0,
		NUM_SIGNED = 2'd1,
		NUM_DIGITS = 2'd2,
		NUM_DONE   = 2'd3
	} num_phase_t;

	// Tracks widths, held drives and the command parser; queues the drive due per tick.
	class drive_tracker;
		typedef struct {
			logic [US_BITS-1:0] right;
			logic [US_BITS-1:0] left;
			logic [1:0]         md;
			logic               applied;
		} drive_t;

		drive_t                pending_drives[$];
		logic [US_BITS-1:0]    lim_manual, lim_auto, neutral, drv_min, drv_max;
		logic [2:0]            last_levels;
		logic [PULSE_BITS-1:0] timers[3];
		logic [US_BITS-1:0]    right_w, left_w, aux_w, right_hold, left_hold;
		logic [1:0]            n_chars;
		logic [7:0]            lead;
		target_t               tgt;
		num_phase_t            phase;
		logic                  neg;
		logic [6:0]            mag;
		logic                  cmd_ready;
		int                    errors, ticks, results, applied_cnt;
		int                    mode_seen[3];

		function new();
			lim_manual = MANUAL_LIMIT_RST;
			lim_auto = AUTO_LIMIT_RST;
			neutral = NEUTRAL_RST;
			drv_min = DRIVE_MIN_RST;
			drv_max = DRIVE_MAX_RST;
			last_levels = '0;
			foreach (timers[i]) timers[i] = '0;
			right_w = NEUTRAL_RST;
			left_w = NEUTRAL_RST;
			aux_w = AUX_WIDTH_RST;
			right_hold = NEUTRAL_RST;
			left_hold = NEUTRAL_RST;
			clear_cmd();
			errors = 0;
			ticks = 0;
			results = 0;
			applied_cnt = 0;
			foreach (mode_seen[i]) mode_seen[i] = 0;
		endfunction

		function void clear_cmd();
			n_chars = '0;
			lead = '0;
			tgt = TGT_NONE;
			phase = NUM_LEAD;
			neg = 1'b0;
			mag = '0;
			cmd_ready = 1'b0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [US_BITS-1:0] v);
			case (idx)
				REG_MANUAL_LIMIT: lim_manual = v;
				REG_AUTO_LIMIT:   lim_auto = v;
				REG_NEUTRAL:      neutral = v;
				REG_DRIVE_MIN:    drv_min = v;
				REG_DRIVE_MAX:    drv_max = v;
				default: ;
			endcase
		endfunction

		// Signed math so reversed limits scale downward, truncating toward zero.
		function logic [US_BITS-1:0] scaled(logic [6:0] n);
			longint lo, hi, v;
			lo = drv_min;
			hi = drv_max;
			v = (longint'(n) * (hi - lo)) / 100 + lo;
			return v[US_BITS-1:0];
		endfunction

		function void parse_char(logic [7:0] c);
			int   m;
			logic digit, space;
			digit = (c >= CH_ZERO) && (c <= CH_NINE);
			space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
			if (c == CH_OPEN) begin
				clear_cmd();
				return;
			end
			if (c == CH_CLOSE) begin
				cmd_ready = 1'b1;
				return;
			end
			if (n_chars == 2'd0) begin
				lead = c;
				n_chars = 2'd1;
				return;
			end
			if (n_chars == 2'd1) begin
				n_chars = 2'd2;
				if (lead == CH_M && c == CH_R) tgt = TGT_RIGHT;
				else if (lead == CH_M && c == CH_L) tgt = TGT_LEFT;
				else tgt = TGT_NONE;
				return;
			end
			case (phase)
				NUM_LEAD, NUM_SIGNED, NUM_DIGITS: begin
					if (phase == NUM_LEAD && space) ;
					else if (phase == NUM_LEAD && (c == CH_PLUS || c == CH_MINUS)) begin
						neg = (c == CH_MINUS);
						phase = NUM_SIGNED;
					end else if (digit) begin
						m = int'(mag) * 10 + int'(c - CH_ZERO);
						mag = (m > CMD_MAX) ? CMD_MAX : 7'(m);
						phase = NUM_DIGITS;
					end else begin
						phase = NUM_DONE;
					end
				end
				default: ;
			endcase
		endfunction

		function void take_tick(logic r, logic l, logic a, logic bv, logic [7:0] c);
			logic [2:0] lv;
			logic [1:0] md;
			logic       ap;
			drive_t     d;
			lv = {a, l, r};
			ticks++;
			for (int ch = 0; ch < 3; ch++) begin
				if (lv[ch] && !last_levels[ch]) timers[ch] = '0;
				else timers[ch] = timers[ch] + 1'b1;
				if (!lv[ch] && last_levels[ch]) begin
					case (ch)
						0: right_w = timers[ch][US_BITS-1:0];
						1: left_w = timers[ch][US_BITS-1:0];
						default: aux_w = timers[ch][US_BITS-1:0];
					endcase
				end
			end
			last_levels = lv;
			if (bv) parse_char(c);
			ap = 1'b0;
			if (aux_w <= lim_manual) begin
				md = MODE_MANUAL;
				right_hold = right_w;
				left_hold = left_w;
			end else if (aux_w < lim_auto) begin
				md = MODE_DISABLED;
				right_hold = neutral;
				left_hold = neutral;
			end else begin
				md = MODE_AUTO;
				if (cmd_ready) begin
					if (tgt == TGT_RIGHT) right_hold = scaled(neg ? 7'd0 : mag);
					else if (tgt == TGT_LEFT) left_hold = scaled(neg ? 7'd0 : mag);
					clear_cmd();
					ap = 1'b1;
				end
			end
			d.right = right_hold;
			d.left = left_hold;
			d.md = md;
			d.applied = ap;
			pending_drives.push_back(d);
		endfunction

		task report_mismatch(string msg);
			errors++;
			if (errors <= 40) $display("mismatch at result %0d: %s", results, msg);
		endtask

		task match_drive(logic [US_BITS-1:0] r, logic [US_BITS-1:0] l, logic [1:0] md,
				logic ap);
			drive_t d;
			if (pending_drives.size() == 0) begin
				report_mismatch($sformatf("unexpected result right=%0d left=%0d mode=%0d",
					r, l, md));
				return;
			end
			d = pending_drives.pop_front();
			results++;
			mode_seen[d.md]++;
			if (d.applied) applied_cnt++;
			if (r !== d.right)
				report_mismatch($sformatf("right_drive_us %0d, want %0d", r, d.right));
			if (l !== d.left)
				report_mismatch($sformatf("left_drive_us %0d, want %0d", l, d.left));
			if (md !== d.md)
				report_mismatch($sformatf("mode %0d, want %0d", md, d.md));
			if (ap !== d.applied)
				report_mismatch($sformatf("command_applied %0d, want %0d", ap, d.applied));
		endtask

		task check_drained();
			if (pending_drives.size() != 0)
				report_mismatch($sformatf("%0d results never arrived", pending_drives.size()));
		endtask
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [4:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               right_level = 1'b0;
	logic               left_level = 1'b0;
	logic               aux_level = 1'b0;
	logic               byte_valid = 1'b0;
	logic [7:0]         rx_byte = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [US_BITS-1:0] right_drive_us;
	logic [US_BITS-1:0] left_drive_us;
	logic [1:0]         mode;
	logic               command_applied;

	drive_tracker       trk;
	int                 cycle_count = 0;
	logic               stall_req = 1'b0;
	int                 hold_left = 0;
	int                 style = 0;
	int                 style_left = 0;
	int                 settings_done = 0;

	logic [2:0]         gen_lv = '0;
	int                 run_left[3] = '{0, 0, 0};
	logic [7:0]         text_q[$];
	logic [US_BITS-1:0] cfg_manual, cfg_auto;

	rc_pulse_capture_mode_mux DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.right_level(right_level),
		.left_level(left_level),
		.aux_level(aux_level),
		.byte_valid(byte_valid),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.right_drive_us(right_drive_us),
		.left_drive_us(left_drive_us),
		.mode(mode),
		.command_applied(command_applied)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	// Output side: check each accepted result, then pick the next ready level.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				trk.match_drive(right_drive_us, left_drive_us, mode, command_applied);
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_req) begin
				hold_left = LONG_HOLD;
				stall_req <= 1'b0;
				out_ready <= 1'b0;
			end else begin
				if (style_left == 0) begin
					style = $urandom_range(0, 3);
					style_left = $urandom_range(20, 200);
				end
				style_left--;
				case (style)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= ($urandom_range(0, 7) != 0);
					default: out_ready <= ((cycle_count % 7) < 4);
				endcase
			end
		end
	end

	task automatic send_tick(logic r, logic l, logic a, logic bv, logic [7:0] c);
		right_level <= r;
		left_level <= l;
		aux_level <= a;
		byte_valid <= bv;
		rx_byte <= c;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		trk.take_tick(r, l, a, bv, c);
	endtask

	// Feed one character per tick with aux held low, so the mode stays put.
	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0, 1'b1, s[i]);
	endtask

	task automatic drain();
		while (trk.pending_drives.size() != 0) @(posedge clk);
	endtask

	task automatic apb_write(logic [2:0] idx, logic [31:0] v);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apb_read(logic [2:0] idx, output logic [31:0] v);
		psel <= 1'b1;
		pwrite <= 1'b0;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		v = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_setting(logic [US_BITS-1:0] m, logic [US_BITS-1:0] a,
			logic [US_BITS-1:0] n, logic [US_BITS-1:0] lo, logic [US_BITS-1:0] hi);
		logic [US_BITS-1:0] vals[5];
		logic [2:0]         regs[5];
		logic [31:0]        rd;
		vals = '{m, a, n, lo, hi};
		regs = '{REG_MANUAL_LIMIT, REG_AUTO_LIMIT, REG_NEUTRAL, REG_DRIVE_MIN, REG_DRIVE_MAX};
		drain();
		repeat (4) @(posedge clk);
		for (int i = 0; i < 5; i++) begin
			apb_write(regs[i], {16'd0, vals[i]});
			trk.set_reg(regs[i], vals[i]);
			apb_read(regs[i], rd);
			if (rd[US_BITS-1:0] !== vals[i])
				trk.report_mismatch($sformatf("register %0d reads %0d, want %0d",
					regs[i], rd[US_BITS-1:0], vals[i]));
		end
		cfg_manual = m;
		cfg_auto = a;
		settings_done++;
	endtask

	// Aux high time: mostly right at the mode limits, else short and random.
	function automatic int aux_len();
		int c;
		case ($urandom_range(0, 7))
			0: c = int'(cfg_manual) - 1;
			1: c = int'(cfg_manual);
			2: c = int'(cfg_manual) + 1;
			3: c = int'(cfg_auto) - 1;
			4: c = int'(cfg_auto);
			5: c = int'(cfg_auto) + 1;
			default: c = $urandom_range(1, 30);
		endcase
		if (c < 1 || c > 60) c = $urandom_range(1, 30);
		return c;
	endfunction

	function automatic logic [7:0] any_char();
		return 8'($urandom_range(0, 255));
	endfunction

	// Queue one serial command, mostly well formed, sometimes broken or pure noise.
	function automatic void fill_text();
		int n;
		if ($urandom_range(0, 9) == 0) begin
			n = $urandom_range(1, 4);
			repeat (n) text_q.push_back(any_char());
			return;
		end
		text_q.push_back(CH_OPEN);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				text_q.push_back(CH_M);
				text_q.push_back(CH_R);
			end
			4, 5, 6, 7: begin
				text_q.push_back(CH_M);
				text_q.push_back(CH_L);
			end
			8: begin
				text_q.push_back(CH_M);
				text_q.push_back(any_char());
			end
			default: begin
				text_q.push_back(any_char());
				text_q.push_back(any_char());
			end
		endcase
		repeat ($urandom_range(0, 2)) begin
			case ($urandom_range(0, 3))
				0: text_q.push_back(CH_SPACE);
				1: text_q.push_back(CH_TAB);
				2: text_q.push_back(CH_CR);
				default: text_q.push_back(8'($urandom_range(CH_TAB, CH_CR)));
			endcase
		end
		if ($urandom_range(0, 3) == 0)
			text_q.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
		n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
		repeat (n) text_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
		if ($urandom_range(0, 6) == 0) text_q.push_back(any_char());
		if ($urandom_range(0, 9) != 0) text_q.push_back(CH_CLOSE);
		// Trailing bytes still extend a command that has not been consumed yet.
		if ($urandom_range(0, 6) == 0)
			text_q.push_back($urandom_range(0, 1) ? 8'(CH_ZERO + $urandom_range(0, 9))
				: any_char());
	endfunction

	function automatic void gen_tick(output logic r, output logic l, output logic a,
			output logic bv, output logic [7:0] c);
		for (int ch = 0; ch < 3; ch++) begin
			if (run_left[ch] == 0) begin
				gen_lv[ch] = !gen_lv[ch];
				if (ch == 2 && gen_lv[ch]) run_left[ch] = aux_len();
				else if (ch == 2) run_left[ch] = $urandom_range(1, 6);
				else run_left[ch] = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(1, 30);
			end
			run_left[ch]--;
		end
		{a, l, r} = gen_lv;
		if (text_q.size() == 0) fill_text();
		if ($urandom_range(0, 2) == 0) begin
			bv = 1'b1;
			c = text_q.pop_front();
		end else begin
			bv = 1'b0;
			c = any_char();
		end
	endfunction

	// Send ticks in bursts; optionally start the long output hold-off or drain midway.
	task automatic run_items(int count, int stall_at, int pause_at);
		int         i, blen;
		logic       r, l, a, bv;
		logic [7:0] c;
		i = 0;
		while (i < count) begin
			blen = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 16);
			for (int k = 0; k < blen && i < count; k++) begin
				if (i == stall_at) stall_req <= 1'b1;
				if (i == pause_at) begin
					in_valid <= 1'b0;
					@(posedge clk);
					drain();
				end
				gen_tick(r, l, a, bv, c);
				send_tick(r, l, a, bv, c);
				i++;
			end
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	initial begin
		trk = new();
		cfg_manual = MANUAL_LIMIT_RST;
		cfg_auto = AUTO_LIMIT_RST;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset aux width is autonomous: plain, negative, saturated, unknown target.
		send_text("[MR42]");
		send_text("[ML-7]");
		send_text("[MR999]");
		send_text("[XY5]");
		in_valid <= 1'b0;
		@(posedge clk);

		load_setting(16'd10, 16'd20, 16'd1500, 16'd1000, 16'd2000);
		run_items(300, 100, -1);
		load_setting(16'd12, 16'd12, 16'd0, 16'd0, 16'd65535);
		run_items(250, -1, -1);
		// Overlapping limits and reversed drive range.
		load_setting(16'd20, 16'd8, 16'd65535, 16'd65535, 16'd0);
		run_items(250, -1, 120);
		load_setting(16'd0, 16'd65535, 16'd777, 16'd1200, 16'd1100);
		run_items(150, -1, -1);
		load_setting(16'd65535, 16'd0, 16'd4242, 16'd0, 16'd0);
		run_items(150, -1, -1);
		load_setting(16'd0, 16'd0, 16'd1, 16'd1999, 16'd3);
		run_items(250, -1, -1);
		load_setting(16'($urandom_range(5, 20)), 16'($urandom_range(5, 25)),
			16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
			16'($urandom_range(0, 65535)));
		run_items(400, 250, 100);

		drain();
		repeat (10) @(posedge clk);
		trk.check_drained();
		$display("Ran %0d ticks over %0d register settings; %0d results checked, %0d commands applied.",
			trk.ticks, settings_done, trk.results, trk.applied_cnt);
		$display("Results by mode: manual %0d, disabled %0d, autonomous %0d.",
			trk.mode_seen[0], trk.mode_seen[1], trk.mode_seen[2]);
		if (trk.errors == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end
endmodule
